// ===== design/rtch_pkg.sv =====
// Shared types and constants for the ray/triangle closest-hit block.
// Used by rtch_ctrl, rtch_dp and ray_triangle_closest_hit.
`default_nettype none
package rtch_pkg;

   localparam int DIST_BITS  = 31;
   localparam int UV_BITS    = 15;
   localparam int INST_BITS  = 16;
   localparam int PRIM_BITS  = 24;
   localparam int FIELD_BITS = 63;
   localparam int EPS_BITS   = 20;
   localparam int MIND_BITS  = 14;

   localparam logic [EPS_BITS-1:0]  EPS_RESET  = 20'd26844;
   localparam logic [MIND_BITS-1:0] MIND_RESET = 14'd2;
   localparam logic [DIST_BITS-1:0] DIST_MAX   = {DIST_BITS{1'b1}};

   // request tdata layout, lowest bit first
   localparam int SD_LSB   = 0;
   localparam int ORG_LSB  = SD_LSB + DIST_BITS;
   localparam int DIR_LSB  = ORG_LSB + FIELD_BITS;
   localparam int VA_LSB   = DIR_LSB + FIELD_BITS;
   localparam int VB_LSB   = VA_LSB + FIELD_BITS;
   localparam int VC_LSB   = VB_LSB + FIELD_BITS;
   localparam int INST_LSB = VC_LSB + FIELD_BITS;
   localparam int PRIM_LSB = INST_LSB + INST_BITS;
   localparam int REQ_DATA_BITS = 392;
   localparam int RSP_DATA_BITS = 104;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = EPS_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PARALLEL_EPSILON = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_DISTANCE     = 1'd1;

   localparam int CNT_BITS = 5;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_H1,
      OP_H2,
      OP_Q1,
      OP_Q2,
      OP_DET,
      OP_NU,
      OP_NV,
      OP_NT,
      OP_CHECK,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_UPDATE,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic pass;
   } status_type;

endpackage
`default_nettype wire

// ===== design/rtch_ctrl.sv =====
// Sequencer for the ray/triangle test: steps the datapath through products,
// check, division and update, and owns the response valid. Uses rtch_pkg.
`default_nettype none
module rtch_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output rtch_pkg::cmd_type    cmd,
   input  rtch_pkg::status_type status
);
   import rtch_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_CHECK,
      S_DECIDE,
      S_DIV,
      S_UPDATE,
      S_OUT
   } state_type;

   localparam logic [2:0]          CALC_LAST = 3'd7;
   localparam logic [CNT_BITS-1:0] DIV_LAST  = CNT_BITS'(DIST_BITS - 1);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               cnt_in   = '0;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            case (cnt_ff[2:0])
               3'd0:    cmd.op = OP_H1;
               3'd1:    cmd.op = OP_H2;
               3'd2:    cmd.op = OP_Q1;
               3'd3:    cmd.op = OP_Q2;
               3'd4:    cmd.op = OP_DET;
               3'd5:    cmd.op = OP_NU;
               3'd6:    cmd.op = OP_NV;
               default: cmd.op = OP_NT;
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[2:0] == CALC_LAST) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.op   = OP_CHECK;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.pass) begin
               cmd.op   = OP_DIV_START;
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.op   = OP_UPDATE;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_tready) |=> state_ff == S_OUT)
      else $error("result dropped while output register busy");
   a_reject: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && !status.pass) |=> state_ff == S_OUT)
      else $error("rejected test did not skip the divider");
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == DIV_LAST) |=> state_ff == S_UPDATE)
      else $error("divider did not end after its last step");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_tvalid) |=> (state_ff == S_CALC && cnt_ff == '0))
      else $error("accepted request did not start the product sequence");

endmodule
`default_nettype wire

// ===== design/rtch_dp.sv =====
// Datapath: three shared multipliers for cross and dot products, the
// acceptance check, a three-lane restoring divider and the closest-hit state.
// Uses rtch_pkg; driven by rtch_ctrl.
`default_nettype none
module rtch_dp #(
   parameter int COORD_BITS = 21,
   parameter int FRAC_BITS  = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rtch_pkg::cmd_type                      cmd,
   output rtch_pkg::status_type                   status,
   input  logic                                   csr_we,
   input  logic [rtch_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [rtch_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                                   new_ray,
   input  logic [rtch_pkg::REQ_DATA_BITS-1:0]     req_data,
   output logic [rtch_pkg::RSP_DATA_BITS-1:0]     rsp_data
);
   import rtch_pkg::*;

   localparam int EW  = COORD_BITS + 1;
   localparam int XW  = 2 * EW + 1 - FRAC_BITS;
   localparam int MW  = (XW > EW) ? XW : EW;
   localparam int PW  = 2 * MW;
   localparam int DW  = EW + XW + 2;
   localparam int SAT = DIST_BITS - FRAC_BITS;

   logic [EPS_BITS-1:0]  eps_ff, eps_in;
   logic [MIND_BITS-1:0] mind_ff, mind_in;

   logic signed [EW-1:0] dir_ff[3], dir_in[3];
   logic signed [EW-1:0] e1_ff[3], e1_in[3];
   logic signed [EW-1:0] e2_ff[3], e2_in[3];
   logic signed [EW-1:0] s_ff[3], s_in[3];
   logic [INST_BITS-1:0] inst_ff, inst_in;
   logic [PRIM_BITS-1:0] prim_ff, prim_in;

   logic signed [PW-1:0] prod_ff[3], prod_in[3];
   logic signed [XW-1:0] h_ff[3], h_in[3];
   logic signed [XW-1:0] q_ff[3], q_in[3];
   logic signed [DW-1:0] det_ff, det_in, nu_ff, nu_in, nv_ff, nv_in, nt_ff, nt_in;
   logic                 pass_ff, pass_in;

   logic [DW-1:0]        rem_ff[3], rem_in[3];
   logic [DIST_BITS-1:0] sh_ff[3], sh_in[3];
   logic [DIST_BITS-1:0] quo_ff[3], quo_in[3];

   logic [DIST_BITS-1:0] best_dist_ff, best_dist_in;
   logic [UV_BITS-1:0]   best_u_ff, best_u_in, best_v_ff, best_v_in;
   logic [INST_BITS-1:0] best_inst_ff, best_inst_in;
   logic [PRIM_BITS-1:0] best_prim_ff, best_prim_in;
   logic                 have_hit_ff, have_hit_in;
   logic                 hit_ff, hit_in;
   logic [RSP_DATA_BITS-1:0] rsp_ff, rsp_in;

   logic signed [MW-1:0] opa[3], opb[3];
   logic signed [PW-1:0] prod[3];
   logic signed [PW:0]   diff[3];
   logic signed [DW-1:0] dsum;
   logic signed [DW-1:0] dn, un, vn, tn;
   logic signed [DW:0]   uv_sum;
   logic [DW+SAT-1:0]    sat_lim;
   logic [DW-1:0]        num[3];
   logic [DW:0]          r2[3];
   logic [DIST_BITS-1:0] t_val;

   // operand selection for the three multiplier lanes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         opa[i] = '0;
         opb[i] = '0;
         case (cmd.op)
            OP_H1: begin
               opa[i] = MW'(dir_ff[(i+1)%3]);
               opb[i] = MW'(e2_ff[(i+2)%3]);
            end
            OP_H2: begin
               opa[i] = MW'(dir_ff[(i+2)%3]);
               opb[i] = MW'(e2_ff[(i+1)%3]);
            end
            OP_Q1: begin
               opa[i] = MW'(s_ff[(i+1)%3]);
               opb[i] = MW'(e1_ff[(i+2)%3]);
            end
            OP_Q2: begin
               opa[i] = MW'(s_ff[(i+2)%3]);
               opb[i] = MW'(e1_ff[(i+1)%3]);
            end
            OP_DET: begin
               opa[i] = MW'(e1_ff[i]);
               opb[i] = MW'(h_ff[i]);
            end
            OP_NU: begin
               opa[i] = MW'(s_ff[i]);
               opb[i] = MW'(h_ff[i]);
            end
            OP_NV: begin
               opa[i] = MW'(dir_ff[i]);
               opb[i] = MW'(q_ff[i]);
            end
            OP_NT: begin
               opa[i] = MW'(e2_ff[i]);
               opb[i] = MW'(q_ff[i]);
            end
            default: ;
         endcase
         prod[i] = opa[i] * opb[i];
         diff[i] = (PW+1)'(prod_ff[i]) - (PW+1)'(prod[i]);
      end
      dsum = DW'(prod[0]) + DW'(prod[1]) + DW'(prod[2]);
   end

   // sign normalization, acceptance-test operands and divider inputs
   always_comb begin
      dn = det_ff[DW-1] ? -det_ff : det_ff;
      un = det_ff[DW-1] ? -nu_ff : nu_ff;
      vn = det_ff[DW-1] ? -nv_ff : nv_ff;
      tn = det_ff[DW-1] ? -nt_ff : nt_ff;
      uv_sum  = (DW+1)'(un) + (DW+1)'(vn);
      sat_lim = (DW+SAT)'($unsigned(dn)) << SAT;
      num[0]  = $unsigned(nt_ff);
      num[1]  = $unsigned(nu_ff);
      num[2]  = $unsigned(nv_ff);
      for (int k = 0; k < 3; k++) begin
         r2[k] = {rem_ff[k], sh_ff[k][DIST_BITS-1]};
      end
      t_val = quo_ff[0];
   end

   always_comb begin
      eps_in  = eps_ff;
      mind_in = mind_ff;
      if (csr_we) begin
         if (csr_index == CSR_PARALLEL_EPSILON) begin
            eps_in = csr_wdata;
         end
         if (csr_index == CSR_MIN_DISTANCE) begin
            mind_in = csr_wdata[MIND_BITS-1:0];
         end
      end

      dir_in  = dir_ff;
      e1_in   = e1_ff;
      e2_in   = e2_ff;
      s_in    = s_ff;
      inst_in = inst_ff;
      prim_in = prim_ff;
      prod_in = prod_ff;
      h_in    = h_ff;
      q_in    = q_ff;
      det_in  = det_ff;
      nu_in   = nu_ff;
      nv_in   = nv_ff;
      nt_in   = nt_ff;
      pass_in = pass_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      best_dist_in = best_dist_ff;
      best_u_in    = best_u_ff;
      best_v_in    = best_v_ff;
      best_inst_in = best_inst_ff;
      best_prim_in = best_prim_ff;
      have_hit_in  = have_hit_ff;
      hit_in       = hit_ff;
      rsp_in       = rsp_ff;

      case (cmd.op)
         OP_LOAD: begin
            for (int k = 0; k < 3; k++) begin
               dir_in[k] = EW'(signed'(req_data[DIR_LSB + k*COORD_BITS +: COORD_BITS]));
               e1_in[k]  = EW'(signed'(req_data[VB_LSB + k*COORD_BITS +: COORD_BITS]))
                         - EW'(signed'(req_data[VA_LSB + k*COORD_BITS +: COORD_BITS]));
               e2_in[k]  = EW'(signed'(req_data[VC_LSB + k*COORD_BITS +: COORD_BITS]))
                         - EW'(signed'(req_data[VA_LSB + k*COORD_BITS +: COORD_BITS]));
               s_in[k]   = EW'(signed'(req_data[ORG_LSB + k*COORD_BITS +: COORD_BITS]))
                         - EW'(signed'(req_data[VA_LSB + k*COORD_BITS +: COORD_BITS]));
            end
            inst_in = req_data[INST_LSB +: INST_BITS];
            prim_in = req_data[PRIM_LSB +: PRIM_BITS];
            hit_in  = 1'b0;
            if (new_ray) begin
               best_dist_in = req_data[SD_LSB +: DIST_BITS];
               best_u_in    = '0;
               best_v_in    = '0;
               best_inst_in = '0;
               best_prim_in = '0;
               have_hit_in  = 1'b0;
            end
         end
         OP_H1, OP_Q1: prod_in = prod;
         OP_H2: begin
            for (int k = 0; k < 3; k++) begin
               h_in[k] = diff[k][FRAC_BITS +: XW];
            end
         end
         OP_Q2: begin
            for (int k = 0; k < 3; k++) begin
               q_in[k] = diff[k][FRAC_BITS +: XW];
            end
         end
         OP_DET: det_in = dsum;
         OP_NU:  nu_in  = dsum;
         OP_NV:  nv_in  = dsum;
         OP_NT:  nt_in  = dsum;
         OP_CHECK: begin
            det_in  = dn;
            nu_in   = un;
            nv_in   = vn;
            nt_in   = tn;
            // a saturated t can never beat the stored distance: reject it here
            pass_in = (dn != '0) && ($unsigned(dn) >= DW'(eps_ff))
                   && !un[DW-1] && (un <= dn) && !vn[DW-1]
                   && (uv_sum <= (DW+1)'(dn)) && !tn[DW-1]
                   && ((DW+SAT)'($unsigned(tn)) < sat_lim);
         end
         OP_DIV_START: begin
            for (int k = 0; k < 3; k++) begin
               rem_in[k] = num[k] >> SAT;
               sh_in[k]  = {num[k][SAT-1:0], {FRAC_BITS{1'b0}}};
               quo_in[k] = '0;
            end
         end
         OP_DIV_STEP: begin
            for (int k = 0; k < 3; k++) begin
               if (r2[k] >= {1'b0, $unsigned(det_ff)}) begin
                  rem_in[k] = DW'(r2[k] - {1'b0, $unsigned(det_ff)});
                  quo_in[k] = {quo_ff[k][DIST_BITS-2:0], 1'b1};
               end else begin
                  rem_in[k] = DW'(r2[k]);
                  quo_in[k] = {quo_ff[k][DIST_BITS-2:0], 1'b0};
               end
               sh_in[k] = sh_ff[k] << 1;
            end
         end
         OP_UPDATE: begin
            if (t_val > DIST_BITS'(mind_ff) && t_val < best_dist_ff) begin
               best_dist_in = t_val;
               best_u_in    = quo_ff[1][UV_BITS-1:0];
               best_v_in    = quo_ff[2][UV_BITS-1:0];
               best_inst_in = inst_ff;
               best_prim_in = prim_ff;
               have_hit_in  = 1'b1;
               hit_in       = 1'b1;
            end
         end
         OP_OUT: begin
            rsp_in = {1'b0, best_prim_ff, best_inst_ff, best_v_ff, best_u_ff,
                      best_dist_ff, have_hit_ff, hit_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff       <= EPS_RESET;
         mind_ff      <= MIND_RESET;
         best_dist_ff <= DIST_MAX;
         best_u_ff    <= '0;
         best_v_ff    <= '0;
         best_inst_ff <= '0;
         best_prim_ff <= '0;
         have_hit_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         pass_ff      <= 1'b0;
      end else begin
         eps_ff       <= eps_in;
         mind_ff      <= mind_in;
         best_dist_ff <= best_dist_in;
         best_u_ff    <= best_u_in;
         best_v_ff    <= best_v_in;
         best_inst_ff <= best_inst_in;
         best_prim_ff <= best_prim_in;
         have_hit_ff  <= have_hit_in;
         hit_ff       <= hit_in;
         pass_ff      <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff  <= dir_in;
      e1_ff   <= e1_in;
      e2_ff   <= e2_in;
      s_ff    <= s_in;
      inst_ff <= inst_in;
      prim_ff <= prim_in;
      prod_ff <= prod_in;
      h_ff    <= h_in;
      q_ff    <= q_in;
      det_ff  <= det_in;
      nu_ff   <= nu_in;
      nv_ff   <= nv_in;
      nt_ff   <= nt_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      quo_ff  <= quo_in;
      rsp_ff  <= rsp_in;
   end

   assign status.pass = pass_ff;
   assign rsp_data    = rsp_ff;

endmodule
`default_nettype wire

// ===== design/ray_triangle_closest_hit.sv =====
// Top level of the fixed-point ray/triangle closest-hit tester.
// Instantiates rtch_ctrl and rtch_dp; uses rtch_pkg.
//
// One request tests one ray against one triangle and always returns one
// response with the closest hit kept so far for the current ray. A request
// whose triangle passes the determinant, barycentric and t tests runs the
// products on three shared multipliers, then a 31-step restoring divider
// that forms t, u and v together; a rejected one skips the divider. No new
// request is taken until the result is in the output register. A finished
// response waits in the output register while the next request is taken.
`default_nettype none
module ray_triangle_closest_hit #(
   parameter int COORD_BITS = 21,
   parameter int FRAC_BITS  = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_we,
   input  logic [rtch_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rtch_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   // requests
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // start_distance, ray_origin, ray_direction, vertex_a, vertex_b,
   // vertex_c, instance_id, primitive_id, zero fill
   input  logic [rtch_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // new_ray
   input  logic                                 req_tuser,
   // responses
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // hit_updated, any_hit, closest_distance, hit_u, hit_v, hit_instance,
   // hit_primitive, zero fill
   output logic [rtch_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);
   import rtch_pkg::*;

   cmd_type    cmd;
   status_type status;

   rtch_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   rtch_dp #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .new_ray   (req_tuser),
      .req_data  (req_tdata),
      .rsp_data  (rsp_tdata)
   );

endmodule
`default_nettype wire
